FILE: rtl/dtst_pkg.sv
package dtst_pkg;

    localparam int CELL_W          = 32;
    localparam int OFFSET_BITS     = 20;
    localparam int DEPTH_W         = 8;
    localparam int COUNT_W         = 20;
    localparam int KIND_W          = 4;
    localparam int CFG_W           = 20;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 160;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [CELL_W-1:0] TK_BEGIN = 32'h0000_0001;
    localparam logic [CELL_W-1:0] TK_ENDN  = 32'h0000_0002;
    localparam logic [CELL_W-1:0] TK_PROP  = 32'h0000_0003;
    localparam logic [CELL_W-1:0] TK_NOP   = 32'h0000_0004;
    localparam logic [CELL_W-1:0] TK_END   = 32'h0000_0009;

    localparam logic [KIND_W-1:0] KIND_NOP         = 4'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN       = 4'd1;
    localparam logic [KIND_W-1:0] KIND_NAME        = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ENDNODE     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PROP        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LENGTH      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_NAMEOFF     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_VALUE       = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END         = 4'd8;
    localparam logic [KIND_W-1:0] KIND_BADTOKEN    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_UNDERFLOW   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_IGNORED     = 4'd11;
    localparam logic [KIND_W-1:0] KIND_ROOTNOTNODE = 4'd12;

    typedef struct packed {
        logic [CELL_W-1:0] cell_req;
        logic              first;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [OFFSET_BITS-1:0] cell_offset;
        logic [DEPTH_W-1:0]     depth;
        logic [OFFSET_BITS-1:0] node_offset;
        logic [OFFSET_BITS-1:0] parent_offset;
        logic                   parent_known;
        logic [CELL_W-1:0]      prop_length;
        logic [CELL_W-1:0]      prop_name_offset;
        logic [COUNT_W-1:0]     value_index;
        logic                   value_last;
    } result_t;

endpackage

FILE: rtl/dtst_in_stage.sv
module dtst_in_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dtst_pkg::S_TDATA_W-1:0]      s_data,
    input  logic [dtst_pkg::S_TUSER_W-1:0]      s_user,
    input  logic                                advance,
    output logic                                item_valid,
    output dtst_pkg::item_t                     item
);
    import dtst_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.cell_req <= s_data[CELL_W-1:0];
            item_reg.first    <= s_user[0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/dtst_walker.sv
module dtst_walker #(
    parameter int STACK_DEPTH = dtst_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dtst_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          item_fire,
    input  dtst_pkg::item_t               item,
    output dtst_pkg::result_t             result
);
    import dtst_pkg::*;

    localparam logic [2:0] PH_ROOT    = 3'd0;
    localparam logic [2:0] PH_TOKEN   = 3'd1;
    localparam logic [2:0] PH_NAME    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_NAMEOFF = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [DEPTH_W-1:0]     STACK_LIM    = DEPTH_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0]     STACK_LIM_P1 = DEPTH_W'(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0]     DEPTH_MAX    = '1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX      = '1;
    localparam logic [COUNT_W-1:0]     COUNT_MAX    = '1;

    logic [CFG_W-1:0]       struct_cells_reg;
    logic [2:0]             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic [DEPTH_W-1:0]     nesting_reg, nesting_next;
    logic [OFFSET_BITS-1:0] current_reg, current_next;
    logic                   node_valid_reg, node_valid_next;
    logic [COUNT_W-1:0]     cells_left_reg, cells_left_next;
    logic [COUNT_W-1:0]     value_count_reg, value_count_next;
    logic [CELL_W-1:0]      held_length_reg, held_length_next;
    logic [CELL_W-1:0]      held_name_reg, held_name_next;
    logic [OFFSET_BITS-1:0] stack_reg  [STACK_DEPTH];
    logic [OFFSET_BITS-1:0] stack_next [STACK_DEPTH];

    // walk state with a restart applied
    logic [2:0]             ph;
    logic [OFFSET_BITS-1:0] pos;
    logic [DEPTH_W-1:0]     nest;
    logic [OFFSET_BITS-1:0] cur;
    logic                   nv;
    logic [COUNT_W-1:0]     cl;
    logic [COUNT_W-1:0]     vc;
    logic [CELL_W-1:0]      hl;
    logic [CELL_W-1:0]      hn;

    logic [CELL_W-1:0]      cell_word;
    logic                   in_range;
    logic                   do_open;
    logic                   do_close;
    logic                   zero_byte;
    logic [CELL_W:0]        len_cells;
    logic [KIND_W-1:0]      kind;
    logic [COUNT_W-1:0]     vidx;
    logic                   vlast;
    logic                   parent_known;
    logic                   is_prop;

    assign cell_word = item.cell_req;
    assign zero_byte = (cell_word[31:24] == 8'h00) || (cell_word[23:16] == 8'h00) ||
                       (cell_word[15:8] == 8'h00) || (cell_word[7:0] == 8'h00);
    assign len_cells = ({1'b0, cell_word} + (CELL_W + 1)'(3)) >> 2;

    always_comb begin
        ph  = item.first ? PH_ROOT : phase_reg;
        pos = item.first ? '0 : position_reg;
        nest = item.first ? '0 : nesting_reg;
        cur = item.first ? '0 : current_reg;
        nv  = item.first ? 1'b0 : node_valid_reg;
        cl  = item.first ? '0 : cells_left_reg;
        vc  = item.first ? '0 : value_count_reg;
        hl  = item.first ? '0 : held_length_reg;
        hn  = item.first ? '0 : held_name_reg;

        phase_next       = ph;
        nesting_next     = nest;
        current_next     = cur;
        node_valid_next  = nv;
        cells_left_next  = cl;
        value_count_next = vc;
        held_length_next = hl;
        held_name_next   = hn;
        stack_next       = stack_reg;
        kind             = KIND_IGNORED;
        vidx             = '0;
        vlast            = 1'b0;
        do_open          = 1'b0;
        do_close         = 1'b0;

        in_range = (pos < struct_cells_reg) && (pos != POS_MAX);

        if (in_range) begin
            unique case (ph)
                PH_ROOT: begin
                    if (cell_word == TK_NOP) begin
                        kind = KIND_NOP;
                    end else if (cell_word == TK_BEGIN) begin
                        kind    = KIND_BEGIN;
                        do_open = 1'b1;
                    end else begin
                        kind       = KIND_ROOTNOTNODE;
                        phase_next = PH_DONE;
                    end
                end
                PH_TOKEN: begin
                    if (cell_word == TK_NOP) begin
                        kind = KIND_NOP;
                    end else if (cell_word == TK_BEGIN) begin
                        kind    = KIND_BEGIN;
                        do_open = 1'b1;
                    end else if (cell_word == TK_ENDN) begin
                        if (nest == '0) begin
                            kind       = KIND_UNDERFLOW;
                            phase_next = PH_DONE;
                        end else begin
                            kind     = KIND_ENDNODE;
                            do_close = 1'b1;
                        end
                    end else if (cell_word == TK_PROP) begin
                        kind             = KIND_PROP;
                        held_length_next = '0;
                        held_name_next   = '0;
                        phase_next       = PH_LEN;
                    end else if (cell_word == TK_END) begin
                        kind       = KIND_END;
                        phase_next = PH_DONE;
                    end else begin
                        kind       = KIND_BADTOKEN;
                        phase_next = PH_DONE;
                    end
                end
                PH_NAME: begin
                    kind = KIND_NAME;
                    if (zero_byte) begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_LEN: begin
                    kind             = KIND_LENGTH;
                    held_length_next = cell_word;
                    cells_left_next  = (len_cells > (CELL_W + 1)'(COUNT_MAX)) ?
                                       COUNT_MAX : len_cells[COUNT_W-1:0];
                    phase_next       = PH_NAMEOFF;
                end
                PH_NAMEOFF: begin
                    kind             = KIND_NAMEOFF;
                    held_name_next   = cell_word;
                    value_count_next = '0;
                    phase_next       = (cl != '0) ? PH_VALUE : PH_TOKEN;
                end
                PH_VALUE: begin
                    kind             = KIND_VALUE;
                    vidx             = vc;
                    vlast            = (cl <= COUNT_W'(1));
                    cells_left_next  = (cl != '0) ? cl - COUNT_W'(1) : cl;
                    value_count_next = vc + COUNT_W'(1);
                    if (cells_left_next == '0) begin
                        phase_next = PH_TOKEN;
                    end
                end
                default: begin
                    kind = KIND_IGNORED;
                end
            endcase
        end

        // stack kept top-first: entry 0 is the innermost stacked node
        if (do_open) begin
            if (nest < STACK_LIM) begin
                stack_next[0] = pos;
                for (int i = 1; i < STACK_DEPTH; i++) begin
                    stack_next[i] = stack_reg[i-1];
                end
            end
            nesting_next    = (nest != DEPTH_MAX) ? nest + DEPTH_W'(1) : nest;
            current_next    = pos;
            node_valid_next = 1'b1;
            phase_next      = PH_NAME;
        end

        if (do_close) begin
            nesting_next = nest - DEPTH_W'(1);
            if (nest <= STACK_LIM) begin
                for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                    stack_next[i] = stack_reg[i+1];
                end
            end
            if ((nesting_next != '0) && (nesting_next <= STACK_LIM)) begin
                current_next    = (nest <= STACK_LIM) ? stack_reg[1] : stack_reg[0];
                node_valid_next = 1'b1;
            end else begin
                current_next    = '0;
                node_valid_next = 1'b0;
            end
        end

        position_next = (pos != POS_MAX) ? pos + OFFSET_BITS'(1) : pos;

        parent_known = node_valid_next && (nesting_next >= DEPTH_W'(2)) &&
                       (nesting_next <= STACK_LIM_P1);
        is_prop      = kind inside {KIND_PROP, KIND_LENGTH, KIND_NAMEOFF, KIND_VALUE};

        result.kind             = kind;
        result.cell_offset      = pos;
        result.depth            = nesting_next;
        result.node_offset      = (node_valid_next && (nesting_next != '0)) ?
                                  current_next : '0;
        result.parent_offset    = !parent_known ? '0 :
                                  (nesting_next <= STACK_LIM) ? stack_next[1] : stack_next[0];
        result.parent_known     = parent_known;
        result.prop_length      = is_prop ? held_length_next : '0;
        result.prop_name_offset = is_prop ? held_name_next : '0;
        result.value_index      = vidx;
        result.value_last       = vlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            struct_cells_reg <= '0;
            phase_reg        <= PH_ROOT;
            position_reg     <= '0;
            nesting_reg      <= '0;
            current_reg      <= '0;
            node_valid_reg   <= 1'b0;
            cells_left_reg   <= '0;
            value_count_reg  <= '0;
            held_length_reg  <= '0;
            held_name_reg    <= '0;
        end else begin
            if (cfg_we) begin
                struct_cells_reg <= cfg_data;
            end
            if (item_fire) begin
                phase_reg       <= phase_next;
                position_reg    <= position_next;
                nesting_reg     <= nesting_next;
                current_reg     <= current_next;
                node_valid_reg  <= node_valid_next;
                cells_left_reg  <= cells_left_next;
                value_count_reg <= value_count_next;
                held_length_reg <= held_length_next;
                held_name_reg   <= held_name_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            stack_reg <= stack_next;
        end
    end

endmodule

FILE: rtl/dtst_out_stage.sv
module dtst_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  dtst_pkg::result_t result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output dtst_pkg::result_t m_result
);
    import dtst_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? item_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: rtl/devicetree_structure_tokenizer_unit.sv
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata cell_req, tuser first
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata fields, tuser kind, tlast value_last
// cfg       in         cfg_valid/cfg_ready           cfg_data struct_cells
//
// one cell per clock while m_axis is not stalled; an input transaction passes through the cell register,
// then the classify/stack update logic, then the result register, which drives m_axis
// aresetn is synchronous, active low; clears the walk state and struct_cells
// cfg_ready is always high
// a stalled m_axis holds its result; s_axis keeps accepting while the cell register can move
module devicetree_structure_tokenizer_unit #(
    parameter int STACK_DEPTH = dtst_pkg::STACK_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cell_req[31:0]
    input  logic [dtst_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // first[0]
    input  logic [dtst_pkg::S_TUSER_W-1:0]     s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cell_offset[19:0], depth[27:20], node_offset[47:28], parent_offset[67:48],
    // parent_known[68], prop_length[100:69], prop_name_offset[132:101],
    // value_index[152:133], zero[159:153]
    output logic [dtst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // kind[3:0]
    output logic [dtst_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dtst_pkg::CFG_W-1:0]         cfg_data
);
    import dtst_pkg::*;

    localparam int PACK_W = OFFSET_BITS + DEPTH_W + OFFSET_BITS + OFFSET_BITS + 1 +
                            CELL_W + CELL_W + COUNT_W;

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;
    result_t m_result;

    assign cfg_ready = 1'b1;

    dtst_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_user     (s_axis_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dtst_walker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .item_fire (item_valid && advance),
        .item      (item),
        .result    (result)
    );

    dtst_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (m_result)
    );

    assign m_axis_tdata = {(M_TDATA_W - PACK_W)'(0),
                           m_result.value_index,
                           m_result.prop_name_offset,
                           m_result.prop_length,
                           m_result.parent_known,
                           m_result.parent_offset,
                           m_result.node_offset,
                           m_result.depth,
                           m_result.cell_offset};
    assign m_axis_tuser = m_result.kind;
    assign m_axis_tlast = m_result.value_last;

endmodule

FILE: rtl/dtst_checker.sv
module dtst_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [dtst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic [dtst_pkg::KIND_W-1:0]        m_axis_tuser,
    input logic                               m_axis_tlast
);
    import dtst_pkg::*;

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // tlast only on value cells
    a_last_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_VALUE)
        else $error("tlast on a non-value cell");

    // unknown parent reports zero offset
    a_parent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[68] |-> m_axis_tdata[67:48] == '0)
        else $error("parent offset set without known parent");

    // underflow only possible at depth zero
    a_underflow_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_UNDERFLOW) |-> m_axis_tdata[27:20] == '0)
        else $error("underflow reported at nonzero depth");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind devicetree_structure_tokenizer_unit dtst_checker u_dtst_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
